[rtl/core/assert_macros.svh]
// Assertion helpers used by the checker in msst_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define MSST_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked property that is checked during reset as well.
`define MSST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/msst_pkg.sv]
package msst_pkg;

   // Result status codes
   localparam logic [2:0] ST_DELETED   = 3'd0;
   localparam logic [2:0] ST_IGNORED   = 3'd1;
   localparam logic [2:0] ST_UPDATED   = 3'd2;
   localparam logic [2:0] ST_CREATED   = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;
   localparam logic [2:0] ST_FOUND     = 3'd5;
   localparam logic [2:0] ST_NOT_FOUND = 3'd6;

   // Source address fields carried on each channel
   localparam int SRC_FIELDS = 4;
   localparam int ADDR_BITS  = 32;
   localparam int SCNT_BITS  = 3;
   localparam int INDEX_BITS = 4;

   // Table row layout: {sources, source count, filter, group, interface}
   localparam int IFA_LSB  = 0;
   localparam int GRP_LSB  = ADDR_BITS;
   localparam int FLT_BIT  = 2 * ADDR_BITS;
   localparam int SCNT_LSB = FLT_BIT + 1;
   localparam int SRC_LSB  = SCNT_LSB + SCNT_BITS;

   typedef logic [SRC_FIELDS-1:0][ADDR_BITS-1:0] src_vec_type;

   // Controller to datapath
   typedef struct packed {
      logic       load_req;   // capture the incoming transaction
      logic       clr_idx;    // restart the scan at entry zero
      logic       inc_idx;    // advance the scan index
      logic       rd_key;     // read the row at the scan index
      logic       rd_next;    // read the row after the scan index
      logic       wr_shift;   // write the last read row at the scan index
      logic       wr_req;     // write the request row at the scan index
      logic       inc_count;  // one entry more
      logic       dec_count;  // one entry less
      logic       set_res;    // latch result code and index
      logic [2:0] res_code;
      logic       load_rsp;   // move the result into the output register
   } msst_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_lookup;
      logic is_delete;
      logic key_match;
      logic at_end;
      logic shift_end;
      logic full;
      logic rsp_free;
   } msst_stat_type;

endpackage

[rtl/core/msst_ram.sv]
module msst_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/msst_datapath.sv]
module msst_datapath import msst_pkg::*; #(
   parameter int TABLE_DEPTH = 16,
   parameter int MAX_SOURCES = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  msst_cmd_type         cmd,
   output msst_stat_type        stat,
   input  logic                 req_mode,
   input  logic [31:0]          req_interface_address,
   input  logic [31:0]          req_group_address,
   input  logic                 req_filter_mode,
   input  logic [2:0]           req_source_count,
   input  src_vec_type          req_src,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_status,
   output logic [3:0]           rsp_entry_index,
   output logic                 rsp_found_filter_mode,
   output logic [2:0]           rsp_found_source_count,
   output src_vec_type          rsp_src
);

   localparam int SLOT_N = (MAX_SOURCES < SRC_FIELDS) ? MAX_SOURCES : SRC_FIELDS;
   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ROW_W  = SRC_LSB + SLOT_N * ADDR_BITS;

   logic                 req_mode_ff, req_mode_in;
   logic [31:0]          req_ifa_ff, req_ifa_in;
   logic [31:0]          req_grp_ff, req_grp_in;
   logic                 req_fmode_ff, req_fmode_in;
   logic [2:0]           req_scnt_ff, req_scnt_in;
   logic [31:0]          req_src_ff [SLOT_N];
   logic [31:0]          req_src_in [SLOT_N];

   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     idx_next;
   logic [CNT_W+3:0]     idx_wide;

   logic [2:0]           res_code_ff, res_code_in;
   logic [3:0]           res_index_ff, res_index_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_status_ff, rsp_status_in;
   logic [3:0]           rsp_index_ff, rsp_index_in;
   logic                 rsp_fmode_ff, rsp_fmode_in;
   logic [2:0]           rsp_scnt_ff, rsp_scnt_in;
   src_vec_type          rsp_src_ff, rsp_src_in;

   logic                 ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [ROW_W-1:0]     ram_wr_data, ram_rd_data, req_row;

   assign idx_next = idx_ff + CNT_W'(1);
   assign idx_wide = {4'b0000, idx_ff};

   // Request capture, source count clamped to the stored slots
   always_comb begin
      req_mode_in  = req_mode_ff;
      req_ifa_in   = req_ifa_ff;
      req_grp_in   = req_grp_ff;
      req_fmode_in = req_fmode_ff;
      req_scnt_in  = req_scnt_ff;
      req_src_in   = req_src_ff;
      if (cmd.load_req) begin
         req_mode_in  = req_mode;
         req_ifa_in   = req_interface_address;
         req_grp_in   = req_group_address;
         req_fmode_in = req_filter_mode;
         req_scnt_in  = (req_source_count > 3'(SLOT_N)) ? 3'(SLOT_N) : req_source_count;
         for (int i = 0; i < SLOT_N; i++) begin
            req_src_in[i] = req_src[i];
         end
      end
   end

   // Row written on create and update; unused slots stored as zero
   always_comb begin
      req_row = '0;
      req_row[IFA_LSB +: ADDR_BITS]  = req_ifa_ff;
      req_row[GRP_LSB +: ADDR_BITS]  = req_grp_ff;
      req_row[FLT_BIT]               = req_fmode_ff;
      req_row[SCNT_LSB +: SCNT_BITS] = req_scnt_ff;
      for (int i = 0; i < SLOT_N; i++) begin
         if (3'(i) < req_scnt_ff) begin
            req_row[SRC_LSB + i * ADDR_BITS +: ADDR_BITS] = req_src_ff[i];
         end
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.clr_idx) begin
         idx_in = '0;
      end else if (cmd.inc_idx) begin
         idx_in = idx_next;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.inc_count) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.dec_count) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      res_code_in  = res_code_ff;
      res_index_in = res_index_ff;
      if (cmd.set_res) begin
         res_code_in = cmd.res_code;
         if (cmd.res_code inside {ST_IGNORED, ST_FULL, ST_NOT_FOUND}) begin
            res_index_in = '0;
         end else begin
            res_index_in = idx_wide[3:0];
         end
      end
   end

   // Output register; found fields come from the row still held by the RAM
   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_fmode_in  = rsp_fmode_ff;
      rsp_scnt_in   = rsp_scnt_ff;
      rsp_src_in    = rsp_src_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_code_ff;
         rsp_index_in  = res_index_ff;
         rsp_fmode_in  = 1'b0;
         rsp_scnt_in   = '0;
         rsp_src_in    = '0;
         if (res_code_ff == ST_FOUND) begin
            rsp_fmode_in = ram_rd_data[FLT_BIT];
            rsp_scnt_in  = ram_rd_data[SCNT_LSB +: SCNT_BITS];
            for (int i = 0; i < SLOT_N; i++) begin
               if (3'(i) < ram_rd_data[SCNT_LSB +: SCNT_BITS]) begin
                  rsp_src_in[i] = ram_rd_data[SRC_LSB + i * ADDR_BITS +: ADDR_BITS];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_mode_ff   <= req_mode_in;
      req_ifa_ff    <= req_ifa_in;
      req_grp_ff    <= req_grp_in;
      req_fmode_ff  <= req_fmode_in;
      req_scnt_ff   <= req_scnt_in;
      req_src_ff    <= req_src_in;
      idx_ff        <= idx_in;
      res_code_ff   <= res_code_in;
      res_index_ff  <= res_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_fmode_ff  <= rsp_fmode_in;
      rsp_scnt_ff   <= rsp_scnt_in;
      rsp_src_ff    <= rsp_src_in;
   end

   assign ram_rd_en   = cmd.rd_key | cmd.rd_next;
   assign ram_rd_addr = cmd.rd_next ? idx_next[ADDR_W-1:0] : idx_ff[ADDR_W-1:0];
   assign ram_wr_en   = cmd.wr_shift | cmd.wr_req;
   assign ram_wr_data = cmd.wr_shift ? ram_rd_data : req_row;

   msst_ram #(
      .WIDTH (ROW_W),
      .DEPTH (TABLE_DEPTH),
      .ADDR_W(ADDR_W)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(idx_ff[ADDR_W-1:0]),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign stat.is_lookup = req_mode_ff;
   assign stat.is_delete = ~req_fmode_ff & (req_scnt_ff == 3'd0);
   assign stat.key_match = (ram_rd_data[IFA_LSB +: ADDR_BITS] == req_ifa_ff) &&
                           (ram_rd_data[GRP_LSB +: ADDR_BITS] == req_grp_ff);
   assign stat.at_end    = (idx_ff == count_ff);
   assign stat.shift_end = (idx_next == count_ff);
   assign stat.full      = (count_ff == CNT_W'(TABLE_DEPTH));
   assign stat.rsp_free  = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_entry_index        = rsp_index_ff;
   assign rsp_found_filter_mode  = rsp_fmode_ff;
   assign rsp_found_source_count = rsp_scnt_ff;
   assign rsp_src                = rsp_src_ff;

endmodule

[rtl/core/msst_ctrl.sv]
module msst_ctrl import msst_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  msst_stat_type stat,
   output msst_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SRCH_RD  = 3'd1;
   localparam logic [2:0] S_SRCH_CMP = 3'd2;
   localparam logic [2:0] S_SHIFT_RD = 3'd3;
   localparam logic [2:0] S_SHIFT_WR = 3'd4;
   localparam logic [2:0] S_RESULT   = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               cmd.clr_idx  = 1'b1;
               state_in     = S_SRCH_RD;
            end
         end
         S_SRCH_RD: begin
            if (stat.at_end) begin
               // no match in the table
               cmd.set_res = 1'b1;
               state_in    = S_RESULT;
               if (stat.is_lookup) begin
                  cmd.res_code = ST_NOT_FOUND;
               end else if (stat.is_delete) begin
                  cmd.res_code = ST_IGNORED;
               end else if (stat.full) begin
                  cmd.res_code = ST_FULL;
               end else begin
                  cmd.res_code  = ST_CREATED;
                  cmd.wr_req    = 1'b1;
                  cmd.inc_count = 1'b1;
               end
            end else begin
               cmd.rd_key = 1'b1;
               state_in   = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            if (stat.key_match) begin
               cmd.set_res = 1'b1;
               if (stat.is_lookup) begin
                  cmd.res_code = ST_FOUND;
                  state_in     = S_RESULT;
               end else if (stat.is_delete) begin
                  cmd.res_code = ST_DELETED;
                  state_in     = S_SHIFT_RD;
               end else begin
                  cmd.res_code = ST_UPDATED;
                  cmd.wr_req   = 1'b1;
                  state_in     = S_RESULT;
               end
            end else begin
               cmd.inc_idx = 1'b1;
               state_in    = S_SRCH_RD;
            end
         end
         S_SHIFT_RD: begin
            if (stat.shift_end) begin
               cmd.dec_count = 1'b1;
               state_in      = S_RESULT;
            end else begin
               cmd.rd_next = 1'b1;
               state_in    = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.inc_idx  = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_RESULT: begin
            // hold until the output register can take the result
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/multicast_socket_state_table.sv]
// A lookup or update that hits entry h scans entries zero to h; a miss or a delete reads
// every one of the n entries in the table (one RAM read per entry).
// One transaction at a time: the next is taken in the cycle after the result moves
// to the output register, which may still wait on rsp_ready.
// Reset (synchronous, active high): table empty, controller idle, no result pending;
// the entry RAM is not cleared and needs no clearing pass.
module multicast_socket_state_table import msst_pkg::*; #(
   parameter int TABLE_DEPTH = 16,
   parameter int MAX_SOURCES = 4
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [31:0] req_interface_address,
   input  logic [31:0] req_group_address,
   input  logic        req_filter_mode,
   input  logic [2:0]  req_source_count,
   input  logic [31:0] req_source_0,
   input  logic [31:0] req_source_1,
   input  logic [31:0] req_source_2,
   input  logic [31:0] req_source_3,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_entry_index,
   output logic        rsp_found_filter_mode,
   output logic [2:0]  rsp_found_source_count,
   output logic [31:0] rsp_found_source_0,
   output logic [31:0] rsp_found_source_1,
   output logic [31:0] rsp_found_source_2,
   output logic [31:0] rsp_found_source_3
);

   // The table lives in one RAM, one row per entry holding key, filter mode,
   // source count and sources. Every transaction scans the rows from entry
   // zero: each row is read in S_SRCH_RD and its key compared in S_SRCH_CMP. The scan
   // stops at the first match (lowest index) or at the fill count.
   //
   // A delete of entry h copies each later row one place down, a read and a
   // write per row, then drops the fill count. Create writes at the fill
   // count; update rewrites the matching row in place.
   //
   // The result code and index are latched in the datapath when decided; on a
   // lookup hit the RAM read register keeps the found row until the result is
   // loaded into the output register.

   msst_cmd_type  cmd;
   msst_stat_type stat;
   src_vec_type   req_src;
   src_vec_type   rsp_src;

   assign req_src = {req_source_3, req_source_2, req_source_1, req_source_0};

   msst_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   msst_datapath #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .MAX_SOURCES(MAX_SOURCES)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .req_mode              (req_mode),
      .req_interface_address (req_interface_address),
      .req_group_address     (req_group_address),
      .req_filter_mode       (req_filter_mode),
      .req_source_count      (req_source_count),
      .req_src               (req_src),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_entry_index       (rsp_entry_index),
      .rsp_found_filter_mode (rsp_found_filter_mode),
      .rsp_found_source_count(rsp_found_source_count),
      .rsp_src               (rsp_src)
   );

   // Unpack the found sources onto their own ports
   assign rsp_found_source_0 = rsp_src[0];
   assign rsp_found_source_1 = rsp_src[1];
   assign rsp_found_source_2 = rsp_src[2];
   assign rsp_found_source_3 = rsp_src[3];

endmodule

[rtl/core/msst_checker.sv]
`include "assert_macros.svh"

module msst_checker import msst_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic [3:0] rsp_entry_index,
   input logic       rsp_found_filter_mode,
   input logic [2:0] rsp_found_source_count
);

   // A stalled result holds its status
   `MSST_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)), "result changed while stalled")

   // Reset leaves the block idle with nothing to deliver
   `MSST_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (req_ready && !rsp_valid), "not idle after reset")

   // One transaction at a time: ready drops after an accept
   `MSST_ASSERT(a_one_busy, clock, reset, (req_valid && req_ready) |=> !req_ready, "accepted while busy")

   // Only a found result carries entry contents
   `MSST_ASSERT(a_found_only, clock, reset, (rsp_valid && rsp_status != ST_FOUND) |-> (!rsp_found_filter_mode && rsp_found_source_count == 3'd0), "payload on non-found result")

   // Ignored, full and not found report index zero
   `MSST_ASSERT(a_index_zero, clock, reset, (rsp_valid && (rsp_status == ST_IGNORED || rsp_status == ST_FULL || rsp_status == ST_NOT_FOUND)) |-> (rsp_entry_index == 4'd0), "index on a no-entry result")

endmodule

bind multicast_socket_state_table msst_checker u_msst_checker (.*);

[verif/multicast_socket_state_table_check.sv]
module multicast_socket_state_table_check import msst_pkg::*; #(
   parameter int TABLE_DEPTH = 16,
   parameter int MAX_SOURCES = 4
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_mode,
   input  logic [31:0] req_interface_address,
   input  logic [31:0] req_group_address,
   input  logic        req_filter_mode,
   input  logic [2:0]  req_source_count,
   input  logic [31:0] req_source_0,
   input  logic [31:0] req_source_1,
   input  logic [31:0] req_source_2,
   input  logic [31:0] req_source_3,

   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_status,
   input  logic [3:0]  rsp_entry_index,
   input  logic        rsp_found_filter_mode,
   input  logic [2:0]  rsp_found_source_count,
   input  logic [31:0] rsp_found_source_0,
   input  logic [31:0] rsp_found_source_1,
   input  logic [31:0] rsp_found_source_2,
   input  logic [31:0] rsp_found_source_3,

   output int          failures,
   output int          outstanding
);

   typedef struct {
      logic [2:0]  status;
      logic [3:0]  index;
      logic        filt;
      logic [2:0]  scnt;
      src_vec_type src;
   } socket_reply_type;

   // Shadow copy of the socket state table
   logic [31:0] row_ifa  [TABLE_DEPTH];
   logic [31:0] row_grp  [TABLE_DEPTH];
   logic        row_filt [TABLE_DEPTH];
   logic [2:0]  row_scnt [TABLE_DEPTH];
   src_vec_type row_src  [TABLE_DEPTH];
   int          live_rows;

   socket_reply_type replies_due[$];

   task automatic report_failure(input string msg);
      $display("%0t: %s", $time, msg);
      failures++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_failure($sformatf("%s: got %h, want %h", name, got, want));
   endtask

   // Apply one transaction to the shadow table and build the reply it earns
   task automatic apply_socket_request(input logic mode, input logic [31:0] ifa,
                                       input logic [31:0] grp, input logic fmode,
                                       input logic [2:0] scnt, input src_vec_type src,
                                       output socket_reply_type reply);
      int hit;
      int row;
      int clamped;
      int slot;
      hit = -1;
      reply = '{default: '0};
      clamped = int'(scnt);
      if (clamped > MAX_SOURCES) clamped = MAX_SOURCES;
      if (clamped > SRC_FIELDS) clamped = SRC_FIELDS;
      for (row = 0; row < live_rows; row++) begin
         if (hit < 0 && row_ifa[row] == ifa && row_grp[row] == grp) hit = row;
      end

      if (mode) begin
         if (hit < 0) begin
            reply.status = ST_NOT_FOUND;
         end else begin
            reply.status = ST_FOUND;
            reply.index  = hit[3:0];
            reply.filt   = row_filt[hit];
            reply.scnt   = row_scnt[hit];
            for (slot = 0; slot < SRC_FIELDS; slot++) begin
               if (slot < MAX_SOURCES && slot < int'(row_scnt[hit]))
                  reply.src[slot] = row_src[hit][slot];
            end
         end
      end else if (!fmode && clamped == 0) begin
         if (hit < 0) begin
            reply.status = ST_IGNORED;
         end else begin
            // close the gap: later rows move down one place
            for (row = hit; row + 1 < live_rows; row++) begin
               row_ifa[row]  = row_ifa[row + 1];
               row_grp[row]  = row_grp[row + 1];
               row_filt[row] = row_filt[row + 1];
               row_scnt[row] = row_scnt[row + 1];
               row_src[row]  = row_src[row + 1];
            end
            live_rows--;
            reply.status = ST_DELETED;
            reply.index  = hit[3:0];
         end
      end else begin
         if (hit >= 0) begin
            row = hit;
            reply.status = ST_UPDATED;
         end else if (live_rows >= TABLE_DEPTH) begin
            row = 0;
            reply.status = ST_FULL;
         end else begin
            row = live_rows;
            live_rows++;
            row_ifa[row] = ifa;
            row_grp[row] = grp;
            reply.status = ST_CREATED;
         end
         if (reply.status != ST_FULL) begin
            row_filt[row] = fmode;
            row_scnt[row] = clamped[2:0];
            for (slot = 0; slot < SRC_FIELDS; slot++)
               row_src[row][slot] = (slot < clamped) ? src[slot] : '0;
            reply.index = row[3:0];
         end
      end
   endtask

   always @(posedge clock) begin
      socket_reply_type want;
      src_vec_type      seen;
      int               slot;
      if (reset) begin
         live_rows = 0;
         replies_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (replies_due.size() == 0) begin
               report_failure($sformatf("reply with status %0d and no transaction pending",
                                        rsp_status));
            end else begin
               want = replies_due.pop_front();
               seen = {rsp_found_source_3, rsp_found_source_2,
                       rsp_found_source_1, rsp_found_source_0};
               check_field("status", 32'(rsp_status), 32'(want.status));
               check_field("entry_index", 32'(rsp_entry_index), 32'(want.index));
               check_field("found_filter_mode", 32'(rsp_found_filter_mode),
                           32'(want.filt));
               check_field("found_source_count", 32'(rsp_found_source_count),
                           32'(want.scnt));
               for (slot = 0; slot < SRC_FIELDS; slot++)
                  check_field($sformatf("found_source_%0d", slot), seen[slot],
                              want.src[slot]);
            end
         end
         if (req_valid && req_ready) begin
            apply_socket_request(req_mode, req_interface_address, req_group_address,
                                 req_filter_mode, req_source_count,
                                 {req_source_3, req_source_2, req_source_1, req_source_0},
                                 want);
            // append at the tail so replies stay in transaction order
            replies_due.insert(replies_due.size(), want);
         end
      end
      outstanding = replies_due.size();
   end

endmodule

[verif/multicast_socket_state_table_test.sv]
module multicast_socket_state_table_test;
   import msst_pkg::*;

   localparam int TABLE_DEPTH  = 16;
   localparam int MAX_SOURCES  = 4;
   localparam int RANDOM_ITEMS = 750;
   // Worst quiet stretch is the long receiver hold-off plus a full-table
   // scan; allow many times that before declaring a hang.
   localparam int QUIET_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic        mode;
      logic [31:0] ifa;
      logic [31:0] grp;
      logic        fmode;
      logic [2:0]  scnt;
      src_vec_type src;
   } socket_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_mode = 1'b0;
   logic [31:0] req_interface_address = '0;
   logic [31:0] req_group_address = '0;
   logic        req_filter_mode = 1'b0;
   logic [2:0]  req_source_count = '0;
   logic [31:0] req_source_0 = '0;
   logic [31:0] req_source_1 = '0;
   logic [31:0] req_source_2 = '0;
   logic [31:0] req_source_3 = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_entry_index;
   logic        rsp_found_filter_mode;
   logic [2:0]  rsp_found_source_count;
   logic [31:0] rsp_found_source_0;
   logic [31:0] rsp_found_source_1;
   logic [31:0] rsp_found_source_2;
   logic [31:0] rsp_found_source_3;

   int failures;
   int outstanding;
   int items_sent;
   int quiet_cycles;
   bit steady;   // both sides stop idling while set

   // Key pool: five interface addresses by four group addresses gives twenty
   // keys, a few more than the table holds, so the table fills and refuses.
   logic [31:0] ifa_pool [5];
   logic [31:0] grp_pool [4];

   always #5 clock = ~clock;

   multicast_socket_state_table #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .MAX_SOURCES(MAX_SOURCES)
   ) u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_mode               (req_mode),
      .req_interface_address  (req_interface_address),
      .req_group_address      (req_group_address),
      .req_filter_mode        (req_filter_mode),
      .req_source_count       (req_source_count),
      .req_source_0           (req_source_0),
      .req_source_1           (req_source_1),
      .req_source_2           (req_source_2),
      .req_source_3           (req_source_3),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_status             (rsp_status),
      .rsp_entry_index        (rsp_entry_index),
      .rsp_found_filter_mode  (rsp_found_filter_mode),
      .rsp_found_source_count (rsp_found_source_count),
      .rsp_found_source_0     (rsp_found_source_0),
      .rsp_found_source_1     (rsp_found_source_1),
      .rsp_found_source_2     (rsp_found_source_2),
      .rsp_found_source_3     (rsp_found_source_3)
   );

   multicast_socket_state_table_check #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .MAX_SOURCES(MAX_SOURCES)
   ) u_check (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_mode               (req_mode),
      .req_interface_address  (req_interface_address),
      .req_group_address      (req_group_address),
      .req_filter_mode        (req_filter_mode),
      .req_source_count       (req_source_count),
      .req_source_0           (req_source_0),
      .req_source_1           (req_source_1),
      .req_source_2           (req_source_2),
      .req_source_3           (req_source_3),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_status             (rsp_status),
      .rsp_entry_index        (rsp_entry_index),
      .rsp_found_filter_mode  (rsp_found_filter_mode),
      .rsp_found_source_count (rsp_found_source_count),
      .rsp_found_source_0     (rsp_found_source_0),
      .rsp_found_source_1     (rsp_found_source_1),
      .rsp_found_source_2     (rsp_found_source_2),
      .rsp_found_source_3     (rsp_found_source_3),
      .failures               (failures),
      .outstanding            (outstanding)
   );

   function automatic src_vec_type rand_sources();
      src_vec_type v;
      for (int i = 0; i < SRC_FIELDS; i++) v[i] = $urandom;
      return v;
   endfunction

   function automatic socket_req_type socket_req(input logic mode, input logic [31:0] ifa,
                                                 input logic [31:0] grp, input logic fmode,
                                                 input logic [2:0] scnt,
                                                 input src_vec_type src);
      socket_req_type r;
      r.mode  = mode;
      r.ifa   = ifa;
      r.grp   = grp;
      r.fmode = fmode;
      r.scnt  = scnt;
      r.src   = src;
      return r;
   endfunction

   // Offer one transaction and hold it until the block takes it. Any idle
   // gap goes in front, so valid never drops once raised.
   task automatic offer_request(input socket_req_type r);
      while (!steady && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_mode              <= r.mode;
      req_interface_address <= r.ifa;
      req_group_address     <= r.grp;
      req_filter_mode       <= r.fmode;
      req_source_count      <= r.scnt;
      req_source_0          <= r.src[0];
      req_source_1          <= r.src[1];
      req_source_2          <= r.src[2];
      req_source_3          <= r.src[3];
      req_valid             <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // Receiver: random back-pressure, one long hold-off once the run is well
   // under way, and no stalls at all during the steady stretch.
   initial begin : receiver
      int stall_left;
      bit hold_done;
      forever begin
         @(posedge clock);
         if (!hold_done && items_sent >= 300) begin
            stall_left = 200;
            hold_done  = 1'b1;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (steady) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 27);
         end
      end
   end

   // Watchdog: end the run if no transaction moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("multicast_socket_state_table regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      socket_req_type item;
      src_vec_type    ones;
      int             n;
      int             k;
      int             r;
      bit             draining;

      ones = {SRC_FIELDS{32'hFFFF_FFFF}};
      ifa_pool[0] = 32'h0000_0000;
      ifa_pool[1] = 32'hFFFF_FFFF;
      ifa_pool[2] = $urandom;
      ifa_pool[3] = $urandom;
      ifa_pool[4] = $urandom;
      grp_pool[0] = 32'h0000_0000;
      grp_pool[1] = 32'hFFFF_FFFF;
      grp_pool[2] = $urandom;
      grp_pool[3] = $urandom;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-table lookup and delete, creates at the field
      // extremes, oversized source counts, partial source lists, update,
      // delete with shift-down, and delete of a missing key.
      offer_request(socket_req(1'b1, '0, '0, 1'b1, 3'd7, ones));
      offer_request(socket_req(1'b0, '0, '0, 1'b0, 3'd0, ones));
      offer_request(socket_req(1'b0, '0, '0, 1'b1, 3'd0, ones));
      offer_request(socket_req(1'b0, ifa_pool[1], grp_pool[1], 1'b0, 3'd4, ones));
      offer_request(socket_req(1'b0, ifa_pool[0], grp_pool[1], 1'b1, 3'd7, rand_sources()));
      offer_request(socket_req(1'b0, ifa_pool[1], grp_pool[0], 1'b0, 3'd5, rand_sources()));
      offer_request(socket_req(1'b0, ifa_pool[2], grp_pool[2], 1'b0, 3'd1, rand_sources()));
      offer_request(socket_req(1'b1, ifa_pool[0], grp_pool[0], 1'b0, 3'd0, '0));
      offer_request(socket_req(1'b1, ifa_pool[1], grp_pool[1], 1'b0, 3'd0, '0));
      offer_request(socket_req(1'b1, ifa_pool[0], grp_pool[1], 1'b1, 3'd3, ones));
      offer_request(socket_req(1'b1, ifa_pool[1], grp_pool[0], 1'b0, 3'd6, ones));
      offer_request(socket_req(1'b1, ifa_pool[2], grp_pool[2], 1'b1, 3'd7, ones));
      offer_request(socket_req(1'b0, ifa_pool[1], grp_pool[1], 1'b1, 3'd2, rand_sources()));
      offer_request(socket_req(1'b1, ifa_pool[1], grp_pool[1], 1'b0, 3'd0, '0));
      offer_request(socket_req(1'b0, ifa_pool[0], grp_pool[0], 1'b0, 3'd0, ones));
      offer_request(socket_req(1'b1, ifa_pool[1], grp_pool[1], 1'b0, 3'd0, '0));
      offer_request(socket_req(1'b1, ifa_pool[2], grp_pool[2], 1'b0, 3'd0, '0));
      offer_request(socket_req(1'b0, ifa_pool[2], grp_pool[2], 1'b0, 3'd0, rand_sources()));
      offer_request(socket_req(1'b0, ifa_pool[2], grp_pool[2], 1'b0, 3'd0, rand_sources()));
      offer_request(socket_req(1'b1, ifa_pool[2], grp_pool[2], 1'b1, 3'd4, rand_sources()));

      // Random: alternate fill-heavy and drain-heavy phases over the key pool
      // so the table swings between nearly empty and full.
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         steady   = (n >= 450 && n < 600);
         draining = ((n / 125) % 2) == 1;
         k = int'($urandom_range(19));
         item = socket_req(1'b0, ifa_pool[k / 4], grp_pool[k % 4],
                           1'($urandom_range(1)), 3'($urandom_range(7)), rand_sources());
         r = int'($urandom_range(99));
         if (r < 8) begin
            // noise: random key, lookup or delete only, so no stray rows pile up
            item.ifa  = $urandom;
            item.grp  = $urandom;
            item.mode = 1'($urandom_range(1));
            if (!item.mode) begin
               item.fmode = 1'b0;
               item.scnt  = 3'd0;
            end
         end else if (r < 33) begin
            item.mode = 1'b1;
         end else if (r < (draining ? 73 : 43)) begin
            item.fmode = 1'b0;
            item.scnt  = 3'd0;
         end
         offer_request(item);
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      // Drain: let the checker see the last accept, wait for every reply,
      // then hold a little longer for strays
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0 && outstanding == 0)
         $display("multicast_socket_state_table regression: pass");
      else
         $display("multicast_socket_state_table regression: fail");
      $finish;
   end

endmodule
